[design/gn3_pkg.sv]
// Shared types and constants for the gradient noise block.
package gn3_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH   = 2;

    typedef struct packed {
        logic        mode;
        logic [7:0]  table_index;
        logic [7:0]  table_value;
        logic [23:0] coord_x;
        logic [23:0] coord_y;
        logic [23:0] coord_z;
    } t_in_item;

    typedef struct packed {
        logic signed [17:0] noise_value;
        logic [7:0]         pixel_byte;
        logic               saturated;
        logic               load_done;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HASH,
        ST_FADE_A,
        ST_FADE_B,
        ST_GRAD,
        ST_LERP,
        ST_LERP_W,
        ST_FINISH,
        ST_OUT
    } t_state;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

endpackage

[design/gradient_noise_3d.sv]
// Top level of the 3-D gradient noise evaluator.
// A table write (mode 0) goes from the accept step straight to presenting its result.
// An evaluation steps through the accept step, serial hash reads (six reads from the
// registered table memory), the three fade curves (a squaring step, then three steps
// per axis), the eight gradient reads through the single 256-byte table port, the seven
// blends through one shared lerp unit, clamping, and presenting the result. A
// two-entry queue at the input lets the upstream side keep transferring while the
// engine works. The table must be fully written before any evaluation; unwritten
// entries read as undefined.
module gradient_noise_3d #(
    parameter int FRAC_BITS = gn3_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  gn3_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output gn3_pkg::t_out_item o_item
);
    import gn3_pkg::*;

    t_in_item w_q_item;
    logic     w_q_valid, w_q_ready;

    gn3_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_item(i_item),
        .o_valid(w_q_valid), .i_ready(w_q_ready), .o_item(w_q_item)
    );

    gn3_engine #(.FRAC_BITS(FRAC_BITS)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_q_valid), .o_ready(w_q_ready), .i_item(w_q_item),
        .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item)
    );

`ifndef ASSERT_OFF
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("result valid after reset");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(o_item)) else $error("stalled result moved");
    a_load_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.load_done) |-> o_item.noise_value == 18'sd0)
        else $error("load result carries noise");
`endif
endmodule

[design/gn3_queue.sv]
// Two-entry item queue between the front and back ends.
module gn3_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  gn3_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output gn3_pkg::t_in_item o_item
);
    import gn3_pkg::*;

    t_in_item   r_mem [QUEUE_DEPTH];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QUEUE_DEPTH)) else $error("queue overflow");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> r_cnt != 2'd0) else $error("pop from empty queue");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> r_cnt == $past(r_cnt) + 2'd1)
        else $error("queue count slip");
`endif
endmodule

[design/gn3_engine.sv]
// Back end: table memory, hashing, fade, gradients and trilinear blend.
module gn3_engine #(
    parameter int FRAC_BITS = gn3_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  gn3_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output gn3_pkg::t_out_item o_item
);
    import gn3_pkg::*;

    localparam int S    = 1 << FRAC_BITS;
    localparam int VW   = FRAC_BITS + 3;   // signed width of corner/lerp values
    localparam int FW   = FRAC_BITS + 1;   // fade value 0..S

    t_state r_state, n_state;
    logic [7:0] r_mem [256];
    logic [7:0] r_rdata;
    logic [7:0] w_raddr;

    logic [FRAC_BITS-1:0] r_fx [3];
    logic [7:0]           r_ix [3];
    logic [FW-1:0]        r_fade [3];
    logic [2*FRAC_BITS+1:0] r_sq;      // t^2 scratch
    logic [FRAC_BITS+3:0]   r_q;       // fade polynomial part, up to 10*S
    logic [1:0]  r_ax;                 // axis counter for fade
    logic [3:0]  r_cnt;                // general step counter
    logic [7:0]  r_a, r_b;             // A, B
    logic [7:0]  r_h [4];              // AA, AB, BA, BB
    logic signed [VW-1:0] r_g [8];
    logic signed [VW-1:0] r_acc;
    t_out_item   r_out;

    // hash and gradient read address sequence
    always_comb begin
        w_raddr = 8'd0;
        case (r_state)
            ST_HASH: begin
                case (r_cnt)
                    4'd0: w_raddr = r_ix[0];
                    4'd1: w_raddr = r_ix[0] + 8'd1;
                    4'd2: w_raddr = r_a;
                    4'd3: w_raddr = r_a + 8'd1;
                    4'd4: w_raddr = r_b;
                    4'd5: w_raddr = r_b + 8'd1;
                    default: w_raddr = 8'd0;
                endcase
            end
            ST_GRAD: begin
                w_raddr = r_h[{r_cnt[0], r_cnt[1]}] + 8'(r_cnt[2]);
            end
            default: w_raddr = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid && i_item.mode == MODE_LOAD) begin
            r_mem[i_item.table_index] <= i_item.table_value;
        end
        r_rdata <= r_mem[w_raddr];
    end

    function automatic logic signed [VW-1:0] f_grad(
        input logic [3:0] h, input logic signed [VW-1:0] x,
        input logic signed [VW-1:0] y, input logic signed [VW-1:0] z);
        logic signed [VW-1:0] u, v;
        u = (h < 4'd8) ? x : y;
        v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    // gradient for corner index r_cnt-1 (read data lags its address through the r_rdata register)
    logic [2:0] w_gc;
    logic signed [VW-1:0] w_rx, w_ry, w_rz;
    assign w_gc = 3'(r_cnt - 4'd1);
    assign w_rx = $signed({3'b000, r_fx[0]}) - (w_gc[0] ? VW'(S) : VW'(0));
    assign w_ry = $signed({3'b000, r_fx[1]}) - (w_gc[1] ? VW'(S) : VW'(0));
    assign w_rz = $signed({3'b000, r_fx[2]}) - (w_gc[2] ? VW'(S) : VW'(0));

    // shared lerp: a + floor(f*(b-a)/S)
    logic signed [VW-1:0]    w_la, w_lb, w_lr;
    logic [FW-1:0]           w_lf;
    logic signed [VW+FW:0]   w_prod;
    always_comb begin
        w_la = r_g[0];
        w_lb = r_g[1];
        w_lf = r_fade[0];
        case (r_cnt)
            4'd0: begin w_la = r_g[0]; w_lb = r_g[1]; w_lf = r_fade[0]; end
            4'd1: begin w_la = r_g[2]; w_lb = r_g[3]; w_lf = r_fade[0]; end
            4'd2: begin w_la = r_g[4]; w_lb = r_g[5]; w_lf = r_fade[0]; end
            4'd3: begin w_la = r_g[6]; w_lb = r_g[7]; w_lf = r_fade[0]; end
            4'd4: begin w_la = r_g[0]; w_lb = r_g[2]; w_lf = r_fade[1]; end
            4'd5: begin w_la = r_g[4]; w_lb = r_g[6]; w_lf = r_fade[1]; end
            4'd6: begin w_la = r_g[0]; w_lb = r_g[4]; w_lf = r_fade[2]; end
            default: ;
        endcase
        w_prod = $signed({1'b0, w_lf}) * (w_lb - w_la);
        w_lr   = w_la + VW'(w_prod >>> FRAC_BITS);
    end

    // fade: step 0 t^2, step 1 q, step 2 c=t^3>>2F, step 3 c*q
    logic [FRAC_BITS-1:0] w_t;
    assign w_t = r_fx[r_ax];
    logic [2*FRAC_BITS+4:0] w_qfull;
    assign w_qfull = (2*FRAC_BITS+5)'(6) * (2*FRAC_BITS+5)'(r_sq)
                   + ((2*FRAC_BITS+5)'(10) << (2*FRAC_BITS))
                   - (((2*FRAC_BITS+5)'(15) * (2*FRAC_BITS+5)'(w_t)) << FRAC_BITS);
    logic [3*FRAC_BITS-1:0] w_cube;
    assign w_cube = (3*FRAC_BITS)'(r_sq) * (3*FRAC_BITS)'(w_t);
    logic [2*FRAC_BITS+3:0] w_fq;
    assign w_fq = (2*FRAC_BITS+4)'(r_sq[FRAC_BITS-1:0]) * (2*FRAC_BITS+4)'(r_q);

    // clamp and output forming
    logic signed [VW-1:0] w_n;
    logic                 w_sat;
    logic signed [17:0]   w_q16;
    logic [FRAC_BITS+8:0] w_pix;
    always_comb begin
        w_sat = (r_acc > VW'(S)) || (r_acc < -VW'(S));
        w_n = (r_acc > VW'(S)) ? VW'(S) : ((r_acc < -VW'(S)) ? -VW'(S) : r_acc);
        if (FRAC_BITS >= 16) begin
            w_q16 = 18'(w_n >>> (FRAC_BITS >= 16 ? FRAC_BITS - 16 : 0));
        end else begin
            w_q16 = 18'(w_n) <<< (FRAC_BITS < 16 ? 16 - FRAC_BITS : 0);
        end
        w_pix = (FRAC_BITS+9)'(127) * (FRAC_BITS+9)'(VW'(S) + w_n);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_valid) n_state = (i_item.mode == MODE_LOAD) ? ST_OUT : ST_HASH;
            ST_HASH:   if (r_cnt == 4'd6) n_state = ST_FADE_A;
            ST_FADE_A: n_state = ST_FADE_B;
            ST_FADE_B: n_state = (r_cnt == 4'd3 && r_ax == 2'd2) ? ST_GRAD : ST_FADE_B;
            ST_GRAD:   if (r_cnt == 4'd8) n_state = ST_LERP;
            ST_LERP:   if (r_cnt == 4'd5) n_state = ST_LERP_W;
            ST_LERP_W: n_state = ST_FINISH;
            ST_FINISH: n_state = ST_OUT;
            ST_OUT:    if (i_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == ST_IDLE);
        o_valid = (r_state == ST_OUT);
        o_item  = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= 4'd0;
            r_ax      <= 2'd0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    r_cnt <= 4'd0;
                    r_ax  <= 2'd0;
                    if (i_valid) begin
                        r_ix[0] <= 8'(i_item.coord_x >> FRAC_BITS);
                        r_ix[1] <= 8'(i_item.coord_y >> FRAC_BITS);
                        r_ix[2] <= 8'(i_item.coord_z >> FRAC_BITS);
                        r_fx[0] <= i_item.coord_x[FRAC_BITS-1:0];
                        r_fx[1] <= i_item.coord_y[FRAC_BITS-1:0];
                        r_fx[2] <= i_item.coord_z[FRAC_BITS-1:0];
                        r_out   <= '{noise_value: '0, pixel_byte: '0,
                                     saturated: 1'b0, load_done: 1'b1};
                    end
                end
                ST_HASH: begin
                    // data for address of previous step
                    r_cnt <= r_cnt + 4'd1;
                    case (r_cnt)
                        4'd1: r_a <= r_rdata + r_ix[1];
                        4'd2: r_b <= r_rdata + r_ix[1];
                        4'd3: r_h[0] <= r_rdata + r_ix[2];
                        4'd4: r_h[1] <= r_rdata + r_ix[2];
                        4'd5: r_h[2] <= r_rdata + r_ix[2];
                        4'd6: r_h[3] <= r_rdata + r_ix[2];
                        default: ;
                    endcase
                    if (r_cnt == 4'd6) r_cnt <= 4'd0;
                end
                ST_FADE_A: begin
                    r_sq  <= (2*FRAC_BITS+2)'(w_t) * (2*FRAC_BITS+2)'(w_t);
                    r_cnt <= 4'd1;
                end
                ST_FADE_B: begin
                    case (r_cnt)
                        4'd1: begin
                            r_q   <= (FRAC_BITS+4)'(w_qfull >> FRAC_BITS);
                            r_cnt <= 4'd2;
                        end
                        4'd2: begin
                            r_sq  <= (2*FRAC_BITS+2)'(w_cube >> (2*FRAC_BITS));
                            r_cnt <= 4'd3;
                        end
                        4'd3: begin
                            r_fade[r_ax] <= FW'(w_fq >> FRAC_BITS);
                            r_sq  <= (2*FRAC_BITS+2)'(r_fx[r_ax + 2'd1])
                                   * (2*FRAC_BITS+2)'(r_fx[r_ax + 2'd1]);
                            r_ax  <= r_ax + 2'd1;
                            r_cnt <= (r_ax == 2'd2) ? 4'd0 : 4'd1;
                        end
                        default: r_cnt <= 4'd1;
                    endcase
                end
                ST_GRAD: begin
                    if (r_cnt != 4'd0) r_g[w_gc] <= f_grad(r_rdata[3:0], w_rx, w_ry, w_rz);
                    r_cnt <= (r_cnt == 4'd8) ? 4'd0 : r_cnt + 4'd1;
                end
                ST_LERP: begin
                    case (r_cnt)
                        4'd0: r_g[0] <= w_lr;
                        4'd1: r_g[2] <= w_lr;
                        4'd2: r_g[4] <= w_lr;
                        4'd3: r_g[6] <= w_lr;
                        4'd4: r_g[0] <= w_lr;
                        4'd5: r_g[4] <= w_lr;
                        default: ;
                    endcase
                    r_cnt <= r_cnt + 4'd1;
                end
                ST_LERP_W: begin
                    r_acc <= w_lr;
                end
                ST_FINISH: begin
                    r_out <= '{noise_value: w_q16,
                               pixel_byte: 8'(w_pix >> FRAC_BITS),
                               saturated: w_sat, load_done: 1'b0};
                end
                default: ;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(o_item))
        else $error("result changed while stalled");
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("engine busy and idle at once");
    a_load_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.load_done) |-> (o_item.pixel_byte == 8'd0 && !o_item.saturated))
        else $error("load result not cleared");
`endif
endmodule

[bench/gradient_noise_3d_chk.sv]
// Checker for the gradient noise block: watches both channels, predicts and compares.
module gradient_noise_3d_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  gn3_pkg::t_in_item  i_item,
    input  logic               o_valid,
    input  logic               i_ready,
    input  gn3_pkg::t_out_item o_item,
    output int                 o_fail_count,
    output int                 o_pending
);
    import gn3_pkg::*;

    localparam int FB = 16;
    localparam longint ONE = 64'sd1 <<< FB;

    logic [7:0] perm [256];
    t_out_item  noise_due [$];

    function automatic longint floor_q(longint v);
        if (v >= 0) begin
            return v >>> FB;
        end
        return -(((-v) + ONE - 1) >>> FB);
    endfunction

    function automatic longint ease(longint t);
        longint q;
        longint c;
        q = (6 * t * t + 10 * ONE * ONE - 15 * t * ONE) >>> FB;
        c = (t * t * t) >>> (2 * FB);
        return (c * q) >>> FB;
    endfunction

    function automatic longint mix(longint f, longint a, longint b);
        return a + floor_q(f * (b - a));
    endfunction

    function automatic longint grad_dot(logic [7:0] hash, longint x, longint y, longint z);
        logic [3:0] h;
        longint u;
        longint v;
        h = hash[3:0];
        u = (h < 8) ? x : y;
        v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    function automatic t_out_item predict_noise(t_in_item it);
        t_out_item  r;
        logic [7:0] xi, yi, zi, a, b, aa, ab, ba, bb;
        longint x, y, z, u, v, w, raw, n;
        r = '0;
        if (it.mode == MODE_LOAD) begin
            perm[it.table_index] = it.table_value;
            r.load_done = 1'b1;
            return r;
        end
        xi = it.coord_x[23:16];
        yi = it.coord_y[23:16];
        zi = it.coord_z[23:16];
        x = longint'(it.coord_x[15:0]);
        y = longint'(it.coord_y[15:0]);
        z = longint'(it.coord_z[15:0]);
        u = ease(x);
        v = ease(y);
        w = ease(z);
        a  = perm[xi] + yi;
        aa = perm[a] + zi;
        ab = perm[8'(a + 1)] + zi;
        b  = perm[8'(xi + 1)] + yi;
        ba = perm[b] + zi;
        bb = perm[8'(b + 1)] + zi;
        raw = mix(w,
            mix(v, mix(u, grad_dot(perm[aa], x, y, z),
                          grad_dot(perm[ba], x - ONE, y, z)),
                   mix(u, grad_dot(perm[ab], x, y - ONE, z),
                          grad_dot(perm[bb], x - ONE, y - ONE, z))),
            mix(v, mix(u, grad_dot(perm[8'(aa + 1)], x, y, z - ONE),
                          grad_dot(perm[8'(ba + 1)], x - ONE, y, z - ONE)),
                   mix(u, grad_dot(perm[8'(ab + 1)], x, y - ONE, z - ONE),
                          grad_dot(perm[8'(bb + 1)], x - ONE, y - ONE, z - ONE))));
        n = (raw > ONE) ? ONE : ((raw < -ONE) ? -ONE : raw);
        r.saturated   = (raw > ONE) || (raw < -ONE);
        r.noise_value = 18'(n);
        r.pixel_byte  = 8'((127 * (ONE + n)) >>> FB);
        return r;
    endfunction

    assign o_pending = noise_due.size();

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            noise_due.delete();
        end else begin
            if (i_valid && o_ready) begin
                noise_due.push_back(predict_noise(i_item));
            end
            if (o_valid && i_ready) begin
                if (noise_due.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("unexpected result transfer: %p", o_item);
                    end
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = noise_due.pop_front();
                    if (want !== o_item) begin
                        if (o_fail_count < 10) begin
                            $display("mismatch: expected %p, got %p", want, o_item);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

[bench/gradient_noise_3d_tb.sv]
// Testbench top for the gradient noise block: stimulus, receiver stalls and verdict.
module gradient_noise_3d_tb;
    import gn3_pkg::*;

    localparam int WATCHDOG = 20000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_item;
    int        fail_count;
    int        pending;
    int        idle_cycles;
    bit        hold_off;
    bit        stall_done;

    gradient_noise_3d dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_item(i_item), .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item)
    );

    gradient_noise_3d_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_item(i_item), .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: random stall pattern, plus one long hold-off on request.
    initial begin
        int k;
        i_ready = 1'b0;
        stall_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off && !stall_done) begin
                i_ready <= 1'b0;
                for (k = 0; k < 300; k++) begin
                    @(posedge i_clk);
                end
                stall_done = 1'b1;
            end else if (($urandom_range(0, 99) < 60) || (($time / 2000) % 3 == 0)) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b0;
            end
        end
    end

    // Counts cycles with no transfer on either channel and ends the run as a failure once the count reaches WATCHDOG.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send(t_in_item it);
        i_item  <= it;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic drop_valid();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_in_item make_point(logic [23:0] x, logic [23:0] y, logic [23:0] z);
        t_in_item it;
        it = '0;
        it.mode = MODE_EVAL;
        it.table_index = 8'($urandom);
        it.table_value = 8'($urandom);
        it.coord_x = x;
        it.coord_y = y;
        it.coord_z = z;
        return it;
    endfunction

    function automatic t_in_item make_load(logic [7:0] idx, logic [7:0] val);
        t_in_item it;
        it = '0;
        it.mode = MODE_LOAD;
        it.table_index = idx;
        it.table_value = val;
        it.coord_x = 24'($urandom);
        it.coord_y = 24'($urandom);
        it.coord_z = 24'($urandom);
        return it;
    endfunction

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return {8'($urandom), 16'h0000};
            1:       return {8'($urandom), 16'hFFFF};
            2:       return {8'hFF, 16'($urandom)};
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        int n;
        int burst;
        int gap;
        int g;
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_item   = '0;
        hold_off = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Full table fill before any evaluation; extremes of both fields first.
        send(make_load(8'd0, 8'd255));
        send(make_load(8'd255, 8'd0));
        for (n = 1; n < 255; n++) begin
            send(make_load(8'(n), 8'($urandom)));
        end

        // Directed points: corners and other values of the fraction range, wrapped integer parts.
        send(make_point(24'h000000, 24'h000000, 24'h000000));
        send(make_point(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        send(make_point(24'h00FFFF, 24'h000000, 24'hFF8000));
        send(make_point(24'h008000, 24'h008000, 24'h008000));
        send(make_point(24'hFF0000, 24'h7F0001, 24'h80FFFF));
        send(make_point(24'h12C000, 24'h344000, 24'h560001));
        // Table rewrite between evaluations.
        send(make_load(8'd7, 8'd14));
        send(make_point(24'h070000, 24'h07FFFF, 24'h070001));
        drop_valid();

        // Random part: mostly evaluations, some table rewrites, bursts and gaps.
        n = 0;
        while (n < 190) begin
            burst = $urandom_range(1, 12);
            for (g = 0; g < burst; g++) begin
                if ($urandom_range(0, 99) < 15) begin
                    send(make_load(8'($urandom), 8'($urandom)));
                end else begin
                    send(make_point(rand_coord(), rand_coord(), rand_coord()));
                end
                n++;
                if (n == 60) begin
                    hold_off = 1'b1;
                end
            end
            if (n >= 120 && n < 133) begin
                // Sender pause until the block has drained.
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) begin
                    @(posedge i_clk);
                end
            end else if ($urandom_range(0, 2) != 0) begin
                gap = $urandom_range(1, 40);
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;

        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (60) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
